FILE: rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int PATTERN_STORE = 16;
  localparam int LEN_W         = 5;
  localparam int CNT_W         = 32;
  localparam int OUT_ADDR_W    = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 3'd0,
    CFG_PAT_HI = 3'd1,
    CFG_WILD   = 3'd2,
    CFG_LEN    = 3'd3,
    CFG_BASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0]           pat_lo;
    logic [63:0]           pat_hi;
    logic [15:0]           wild;
    logic [LEN_W-1:0]      len;
    logic [OUT_ADDR_W-1:0] base;
  } cfg_t;

  // Stage-1 beat status handed to the compare stage.
  typedef struct packed {
    logic vld;
    logic last;
  } s1_ctl_t;

endpackage

FILE: rtl/core/wbps_cfg_regs.sv
// Configuration register file: pattern, wildcard mask, length, base address.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_cfg_regs import wbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LO: cfg_d.pat_lo = cfg_data_i[63:0];
        CFG_PAT_HI: cfg_d.pat_hi = cfg_data_i[63:0];
        CFG_WILD:   cfg_d.wild   = cfg_data_i[15:0];
        CFG_LEN:    cfg_d.len    = cfg_data_i[LEN_W-1:0];
        CFG_BASE:   cfg_d.base   = cfg_data_i[OUT_ADDR_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/wbps_window.sv
// Input stage: byte shift window and saturating byte counter for the range.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_window import wbps_pkg::*; #(
  parameter int WIN_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  input  logic                       adv_i,
  output logic [WIN_DEPTH-1:0][7:0]  win_o,
  output logic [CNT_W-1:0]           cnt_o,
  output s1_ctl_t                    ctl_o
);

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d, cnt_base;
  logic                      vld_q, vld_d;
  logic                      end_q;
  logic                      accept;

  assign in_stall_o = vld_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  // end_q: previous beat closed a range, so window and count start over.
  always_comb begin
    win_d[0] = data_byte_i;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_d[i] = end_q ? 8'd0 : win_q[i-1];
    end
    cnt_base = end_q ? '0 : cnt_q;
    cnt_d    = (&cnt_base) ? cnt_base : cnt_base + CNT_W'(1);
    vld_d    = accept ? 1'b1 : (adv_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      end_q <= 1'b1;
    end else begin
      vld_q <= vld_d;
      if (accept) begin
        end_q <= last_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

  assign win_o     = win_q;
  assign cnt_o     = cnt_q;
  assign ctl_o.vld  = vld_q;
  assign ctl_o.last = end_q;

endmodule

FILE: rtl/core/wbps_match.sv
// Compare stage: masked pattern compare, match address, result register.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_match import wbps_pkg::*; #(
  parameter int WIN_DEPTH    = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic [WIN_DEPTH-1:0][7:0]  win_i,
  input  logic [CNT_W-1:0]           cnt_i,
  input  s1_ctl_t                    ctl_i,
  output logic                       adv_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [OUT_ADDR_W-1:0]      match_address_o
);

  localparam int IdxW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int KeepW = (ADDRESS_BITS < OUT_ADDR_W) ? ADDRESS_BITS : OUT_ADDR_W;

  logic [PATTERN_STORE-1:0][7:0] pat;
  logic [WIN_DEPTH-1:0]          hit;
  logic [OUT_ADDR_W-1:0]         addr_mask, addr;
  logic [CNT_W-1:0]              offset;
  logic                          len_ok, cnt_ge, fire, take;

  logic                  out_vld_q, out_vld_d;
  logic                  rep_q, rep_d;
  logic                  found_q, found_d;
  logic [OUT_ADDR_W-1:0] addr_q, addr_d;

  assign adv_o = !out_vld_q || !out_stall_i;
  assign take  = ctl_i.vld && adv_o;

  // Pattern byte k lines up with window entry len-1-k (oldest byte first).
  always_comb begin
    logic [LEN_W:0] d;
    logic [IdxW-1:0] idx;
    pat = {cfg_i.pat_hi, cfg_i.pat_lo};
    for (int k = 0; k < WIN_DEPTH; k++) begin
      d   = {1'b0, cfg_i.len} - (LEN_W+1)'(k) - (LEN_W+1)'(1);
      idx = d[IdxW-1:0];
      hit[k] = ((LEN_W+1)'(k) >= {1'b0, cfg_i.len}) || cfg_i.wild[k] ||
               (win_i[idx] == pat[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < OUT_ADDR_W; i++) begin
      addr_mask[i] = (i < KeepW);
    end
    len_ok = (cfg_i.len != '0) && ({1'b0, cfg_i.len} <= (LEN_W+1)'(WIN_DEPTH));
    cnt_ge = (|cnt_i[CNT_W-1:LEN_W]) || (cnt_i[LEN_W-1:0] >= cfg_i.len);
    offset = cnt_i - CNT_W'(cfg_i.len);
    addr   = (cfg_i.base + OUT_ADDR_W'(offset)) & addr_mask;
    fire   = !rep_q && len_ok && cnt_ge && (&hit);
  end

  always_comb begin
    out_vld_d = out_vld_q;
    rep_d     = rep_q;
    found_d   = found_q;
    addr_d    = addr_q;
    if (take) begin
      out_vld_d = fire || (ctl_i.last && !rep_q);
      found_d   = fire;
      addr_d    = fire ? addr : '0;
      rep_d     = ctl_i.last ? 1'b0 : (rep_q || fire);
    end else if (adv_o) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rep_q     <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      rep_q     <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    addr_q  <= addr_d;
  end

  assign out_valid_o     = out_vld_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule

FILE: rtl/core/wildcard_byte_pattern_search_core.sv
// Top level of the wildcard byte pattern search core.
// Depends on wbps_pkg, wbps_cfg_regs, wbps_window and wbps_match.
`timescale 1ns / 1ps

// Takes one byte of the scanned range per cycle when not stalled and reports
// the first place where the configured pattern matches, wildcard bytes
// matching anything. Each byte is registered into the shift window when
// accepted and compared against the pattern from there; a result (found with
// the match address, or not found on the last byte of a range without a
// match) is registered in the result register; at most one comes per range.
// Sustained rate with no output stall is one byte per cycle, set by the window
// register feeding the parallel masked byte compares. The configuration port
// is always ready; write it only while no results are outstanding.
module wildcard_byte_pattern_search_core import wbps_pkg::*; #(
  parameter int MAX_PATTERN  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [OUT_ADDR_W-1:0] match_address_o
);

  localparam int WinD = (MAX_PATTERN < PATTERN_STORE) ? MAX_PATTERN : PATTERN_STORE;

  cfg_t                 cfg;
  logic [WinD-1:0][7:0] win;
  logic [CNT_W-1:0]     cnt;
  s1_ctl_t              s1_ctl;
  logic                 adv;

  wbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wbps_window #(
    .WIN_DEPTH (WinD)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .adv_i       (adv),
    .win_o       (win),
    .cnt_o       (cnt),
    .ctl_o       (s1_ctl)
  );

  wbps_match #(
    .WIN_DEPTH    (WinD),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_match (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .win_i           (win),
    .cnt_i           (cnt),
    .ctl_i           (s1_ctl),
    .adv_o           (adv),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

endmodule

FILE: tb/wildcard_byte_pattern_search_core_tb.sv
// Self-checking testbench for wildcard_byte_pattern_search_core.
// Depends on wbps_pkg and the core; predicts each scan result and checks it on the output port.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_core_tb;
  import wbps_pkg::*;

  localparam int WINDOW_DEPTH   = 16;
  localparam int RANDOM_ITEMS   = 650;
  localparam int QUIET_TAIL     = 550;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 500;

  typedef struct packed {
    logic                  found;
    logic [OUT_ADDR_W-1:0] addr;
  } scan_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  last_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  found_o;
  logic [OUT_ADDR_W-1:0] match_address_o;

  logic idle_on    = 1'b1;
  logic drain_mode = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   mismatch_count = 0;
  int   items_sent = 0;

  // scan predictor state
  cfg_t            model_cfg;
  logic [7:0]      win_bytes [WINDOW_DEPTH];
  logic [CNT_W-1:0] range_count;
  logic            match_done;
  scan_result_t    expected_results [$];

  wildcard_byte_pattern_search_core dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_stall_i,
    .found_o,
    .match_address_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_window();
    for (int k = 0; k < WINDOW_DEPTH; k++) win_bytes[k] = '0;
    range_count = '0;
    match_done  = 1'b0;
  endfunction

  function automatic void store_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PAT_LO: model_cfg.pat_lo = val;
      CFG_PAT_HI: model_cfg.pat_hi = val;
      CFG_WILD:   model_cfg.wild   = val[15:0];
      CFG_LEN:    model_cfg.len    = val[LEN_W-1:0];
      CFG_BASE:   model_cfg.base   = val[OUT_ADDR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_scan(input logic [7:0] b, input logic last);
    logic [127:0] pat;
    logic         hit;
    int           plen;
    scan_result_t res;
    pat  = {model_cfg.pat_hi, model_cfg.pat_lo};
    plen = int'(model_cfg.len);
    for (int k = WINDOW_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    if (range_count != '1) range_count++;
    hit = 1'b0;
    if (!match_done && plen >= 1 && plen <= WINDOW_DEPTH && range_count >= CNT_W'(plen)) begin
      hit = 1'b1;
      for (int k = 0; k < plen; k++)
        if (!model_cfg.wild[k] && win_bytes[plen-1-k] != pat[8*k +: 8]) hit = 1'b0;
    end
    if (hit) begin
      res.found = 1'b1;
      res.addr  = model_cfg.base + OUT_ADDR_W'(range_count - CNT_W'(plen));
      expected_results = {expected_results, res};
      match_done = 1'b1;
    end
    if (last) begin
      if (!match_done) begin
        res.found = 1'b0;
        res.addr  = '0;
        expected_results = {expected_results, res};
      end
      clear_window();
    end
  endfunction

  // valid is held high across back-to-back beats; a gap lowers it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_scan(b, last);
    items_sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    store_config(idx, val);
  endtask

  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] wild, input logic [63:0] plen,
                              input logic [63:0] base);
    write_register(CFG_PAT_LO, lo);
    write_register(CFG_PAT_HI, hi);
    write_register(CFG_WILD, wild);
    write_register(CFG_LEN, plen);
    write_register(CFG_BASE, base);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    drain_mode <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_mode <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // match wraps the address; the pattern recurs later in the range with no second result
  task automatic test_match_and_wrap();
    apply_config(64'h0000_0000_00A5_FF00, '1, 64'h0, 64'd3, 64'h0000_0000_FFFF_FFFE);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    wait_idle();
  endtask

  task automatic test_wildcard_on_last();
    apply_config(64'h5A00, 64'h0, 64'h1, 64'd2, 64'h1000);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_limits();
    apply_config('1, '1, '1, '1, '1);
    send_byte(8'h00, 1'b1);
    wait_idle();
    apply_config(64'h0, 64'h0, 64'hFFFF, 64'd4, 64'h0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    wait_idle();
  endtask

  // new pattern takes effect on the next beat, window contents survive
  task automatic test_midrange_update();
    apply_config(64'h2211, 64'h0, 64'h0, 64'd2, 64'h40);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    wait_idle();
    apply_config(64'h5544, 64'h0, 64'h0, 64'd2, 64'h40);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    wait_idle();
  endtask

  task automatic test_spare_indexes();
    for (int i = CFG_BASE + 1; i < (1 << CFG_IDX_W); i++)
      write_register(i[CFG_IDX_W-1:0], {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();
  endtask

  task automatic send_random_range();
    logic [127:0] pat;
    logic [7:0]   b;
    int           n, pos, plen, mode;
    pat  = {model_cfg.pat_hi, model_cfg.pat_lo};
    plen = int'(model_cfg.len);
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
    mode = $urandom_range(0, 9);
    pos  = (plen >= 1 && plen <= WINDOW_DEPTH && plen <= n) ? $urandom_range(0, n - plen) : -1;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      if (pos >= 0 && mode < 9 && k >= pos && k < pos + plen && !model_cfg.wild[k-pos]) begin
        b = pat[8*(k-pos) +: 8];
        if (mode >= 7 && k == pos + plen - 1) b = ~b;
      end
      send_byte(b, k == n - 1);
    end
  endtask

  task automatic test_random_scans();
    logic [63:0] lo, hi, wild, plen, base;
    int          start, sel;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      if (items_sent - start >= QUIET_TAIL) idle_on <= 1'b0;
      sel = $urandom_range(0, 9);
      lo  = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
      hi  = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
      wild = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) wild[15:0] = '0;
      else if ($urandom_range(0, 1) == 0) wild[15:0] = wild[15:0] & 16'($urandom);
      sel  = $urandom_range(0, 9);
      plen = {$urandom, $urandom};
      plen[LEN_W-1:0] = (sel == 0) ? '0 : (sel == 1) ? LEN_W'(16) :
                        (sel == 2) ? LEN_W'($urandom_range(17, 31)) :
                        LEN_W'($urandom_range(1, 6));
      sel  = $urandom_range(0, 5);
      base = {$urandom, $urandom};
      base[31:0] = (sel == 0) ? '0 : (sel == 1) ? '1 :
                   (sel == 2) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40)) : base[31:0];
      if ($urandom_range(0, 1) == 0) begin
        wild[63:16] = '0;
        plen[63:LEN_W] = '0;
        base[63:32] = '0;
      end
      apply_config(lo, hi, wild, plen, base);
      repeat ($urandom_range(2, 6)) send_random_range();
    end
  endtask

  always @(posedge clk_i) begin
    if (!idle_on || drain_mode) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    scan_result_t exp_res;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                  found_o, match_address_o));
      end else begin
        exp_res = expected_results.pop_front();
        if (found_o !== exp_res.found)
          report_mismatch($sformatf("found: got %0b exp %0b", found_o, exp_res.found));
        if (match_address_o !== exp_res.addr)
          report_mismatch($sformatf("match_address: got %h exp %h",
                                    match_address_o, exp_res.addr));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    model_cfg = '0;
    clear_window();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_match_and_wrap();
    test_wildcard_on_last();
    test_length_limits();
    test_midrange_update();
    test_spare_indexes();
    test_random_scans();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
